// ===== rtl/msth_pkg.sv =====
`default_nettype none

package msth_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int POS_BITS    = $clog2(MAX_WINDOW);
  localparam int LEN_BITS    = POS_BITS + 1;

  localparam int CMD_BITS    = 2;
  localparam int DELAY_BITS  = 6;
  localparam int WLEN_BITS   = 7;
  localparam int SUM_BITS    = 22;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 22;

  localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_ARM    = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_DRAIN  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_DELAY     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WLEN      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd2;

  localparam logic [WLEN_BITS-1:0]  WLEN_RESET      = 7'd15;
  localparam logic [SUM_BITS-1:0]   THRESHOLD_RESET = 22'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic take_sample;
    logic commit;
    logic arm;
    logic disarm;
    logic drain_emit;
  } ctl_t;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic                armed;
    logic                pend_zero;
    logic                emit_due;
    logic                drain_last;
    logic                slot_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/msth_if.sv =====
`default_nettype none

interface msth_in_if;
  import msth_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [CMD_BITS-1:0]           cmd;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface msth_out_if;
  logic valid;
  logic ready;
  logic detect;
  logic last;

  modport source (output valid, output detect, output last, input ready);
  modport sink   (input valid, input detect, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/msth_ctrl.sv =====
`default_nettype none

module msth_ctrl
  import msth_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output ctl_t       ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.cmd == CMD_SAMPLE) begin
            state_next = ST_SAMPLE;
          end else if (stat.cmd == CMD_DRAIN && stat.armed && !stat.pend_zero) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_SAMPLE: begin
        if (!stat.emit_due || stat.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (stat.slot_free && stat.drain_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctl      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (stat.cmd)
            CMD_SAMPLE: ctl.take_sample = 1'b1;
            CMD_ARM:    ctl.arm = 1'b1;
            CMD_DRAIN: begin
              if (stat.armed && stat.pend_zero) begin
                ctl.disarm = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SAMPLE: ctl.commit = !stat.emit_due || stat.slot_free;
      ST_DRAIN:  ctl.drain_emit = stat.slot_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/msth_dp.sv =====
`default_nettype none

module msth_dp
  import msth_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [CMD_BITS-1:0]           in_cmd,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  wire ctl_t                          ctl,
  output stat_t                              stat,
  msth_out_if.source                         dout
);

  logic [DELAY_BITS-1:0]       delay;
  logic [WLEN_BITS-1:0]        wlen;
  logic signed [SUM_BITS-1:0]  thr;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]         vld;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic                          rd_vld;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic [POS_BITS-1:0]           addr;

  logic [POS_BITS-1:0]         pos;
  logic signed [SUM_BITS-1:0]  sum;
  logic [DELAY_BITS-1:0]       pending;
  logic                        armed;

  logic                        out_valid;
  logic                        out_detect;
  logic                        out_last;

  logic [LEN_BITS-1:0]         eff_len;
  logic [POS_BITS-1:0]         pos_use;
  logic [LEN_BITS-1:0]         pos_inc;
  logic [POS_BITS-1:0]         pos_next;
  logic signed [SUM_BITS-1:0]  old_ext;
  logic signed [SUM_BITS-1:0]  smp_ext;
  logic signed [SUM_BITS-1:0]  sum_next;
  logic                        slot_free;
  logic                        wlen_write;

  // effective window length, clamped to 1..MAX_WINDOW
  always_comb begin
    if (wlen == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (LEN_BITS'(wlen) > LEN_BITS'(MAX_WINDOW)) begin
      eff_len = LEN_BITS'(MAX_WINDOW);
    end else begin
      eff_len = LEN_BITS'(wlen);
    end
  end

  assign pos_use  = ({1'b0, pos} >= eff_len) ? '0 : pos;
  assign pos_inc  = {1'b0, addr} + LEN_BITS'(1);
  assign pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[POS_BITS-1:0];

  // unwritten entries read as zero
  assign old_ext  = rd_vld ? {{(SUM_BITS-SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data} : '0;
  assign smp_ext  = {{(SUM_BITS-SAMPLE_BITS){smp[SAMPLE_BITS-1]}}, smp};
  assign sum_next = sum - old_ext + smp_ext;

  assign slot_free  = !out_valid || dout.ready;
  assign wlen_write = cfg_we && cfg_index == REG_WLEN;

  assign stat.cmd        = in_cmd;
  assign stat.armed      = armed;
  assign stat.pend_zero  = pending == '0;
  assign stat.emit_due   = pending >= delay;
  assign stat.drain_last = pending == DELAY_BITS'(1);
  assign stat.slot_free  = slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay <= '0;
      wlen  <= WLEN_RESET;
      thr   <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY:     delay <= cfg_data[DELAY_BITS-1:0];
        REG_WLEN:      wlen  <= cfg_data[WLEN_BITS-1:0];
        REG_THRESHOLD: thr   <= cfg_data[SUM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      mem[addr] <= smp;
    end
    if (ctl.take_sample) begin
      rd_data <= mem[pos_use];
      rd_vld  <= vld[pos_use];
      smp     <= in_sample;
      addr    <= pos_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || wlen_write) begin
      vld <= '0;
      pos <= '0;
      sum <= '0;
    end else if (ctl.commit) begin
      vld[addr] <= 1'b1;
      pos       <= pos_next;
      sum       <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      armed   <= 1'b0;
    end else begin
      if (ctl.commit && !stat.emit_due) begin
        pending <= pending + DELAY_BITS'(1);
      end else if (ctl.drain_emit) begin
        pending <= pending - DELAY_BITS'(1);
      end
      if (ctl.arm) begin
        armed <= 1'b1;
      end else if (ctl.disarm || (ctl.drain_emit && stat.drain_last)) begin
        armed <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctl.commit && stat.emit_due) || ctl.drain_emit) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && stat.emit_due) begin
      out_detect <= sum_next > thr;
      out_last   <= 1'b1;
    end else if (ctl.drain_emit) begin
      out_detect <= sum > thr;
      out_last   <= stat.drain_last;
    end
  end

  assign dout.valid  = out_valid;
  assign dout.detect = out_detect;
  assign dout.last   = out_last;

endmodule

`default_nettype wire

// ===== rtl/moving_sum_threshold_lookahead.sv =====
// moving window sum with threshold decision and look-ahead delay
//
// din carries one command per beat: sample (with a Q8.8 sample), arm flush,
// or drain tick. dout carries one decision per beat: detect and last.
// cfg_we/cfg_index/cfg_data write lookahead_delay (0), window_length (1)
// and threshold (2); a write to window_length empties the window.
//
// a sample beat first reads the oldest window entry from the 64-entry
// store, then updates the sum and writes the new entry, waiting while a
// due decision finds the output register full. its decision, if any, is
// loaded into the output register together with that update. arm and
// non-emitting drain beats are handled in the idle state. an armed drain
// is accepted in the idle state and then gives one result per cycle while
// the output register can take one, pending count results in all.
// the output register lets a result wait while the next beat is taken;
// while the receiver stalls a waiting result holds and further results wait.
// reset restores the default registers and an empty window at once, with
// no clearing pass.
`default_nettype none

module moving_sum_threshold_lookahead
  import msth_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  msth_in_if.sink                       din,
  msth_out_if.source                    dout
);

  ctl_t  ctl;
  stat_t stat;
  logic  in_ready;

  assign din.ready = in_ready;

  msth_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  msth_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_cmd    (din.cmd),
    .in_sample (din.sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .stat      (stat),
    .dout      (dout)
  );

endmodule

`default_nettype wire
